FILE: hw/rtl/dssu_pkg.sv
// shared constants, types and helper functions for the dark seam pixel statistics unit
`default_nettype none
package dssu_pkg;

	// frame geometry limits
	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;

	// counter and geometry widths
	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
	localparam int LIM_W = WID_W + HGT_W;

	// configuration register widths
	localparam int THR_W      = 10;
	localparam int FW_CFG_W   = 8;
	localparam int FH_CFG_W   = 8;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 2;

	// configuration reset values
	localparam int RST_THRESHOLD = 80;
	localparam int RST_WIDTH     = 128;
	localparam int RST_HEIGHT    = 128;

	// seam found only when total dark count is at most frame size over eight
	localparam int LIM_SHIFT = 3;

	// payload widths
	localparam int PIX_W       = 8;
	localparam int COUNT_W     = 14;
	localparam int SUM_W       = 20;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_BITS    = 1 + 2 * COUNT_W + 4 * SUM_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH     = 2'd1,
		REG_HEIGHT    = 2'd2
	} cfg_reg_t;

	// effective frame geometry and threshold
	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [WID_W-1:0] width;
		logic [WID_W-1:0] half;
		logic [HGT_W-1:0] height;
		logic [LIM_W-1:0] limit;
	} geom_t;

	// pixel held in the input register
	typedef struct packed {
		logic valid;
		logic dark;
	} pix_t;

	// accumulator status for checking
	typedef struct packed {
		logic frame_end;
		logic col_zero;
		logic row_zero;
	} acc_stat_t;

	// saturating increment of a dark count
	function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] acc);
		logic [COUNT_W:0] s;
		s = {1'b0, acc} + {{COUNT_W{1'b0}}, 1'b1};
		return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
	endfunction

	// saturating add of an index into a sum
	function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
			input logic [SUM_W-1:0] v);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + {1'b0, v};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dssu_cfg.sv
// configuration registers, geometry clamping and registered dark count limit
`default_nettype none
module dssu_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [dssu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dssu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output dssu_pkg::geom_t                       geom
);

	localparam int WEXT_W = (dssu_pkg::WID_W > dssu_pkg::FW_CFG_W) ?
		dssu_pkg::WID_W : dssu_pkg::FW_CFG_W;
	localparam int HEXT_W = (dssu_pkg::HGT_W > dssu_pkg::FH_CFG_W) ?
		dssu_pkg::HGT_W : dssu_pkg::FH_CFG_W;
	localparam int RST_LIMIT = (dssu_pkg::RST_WIDTH * dssu_pkg::RST_HEIGHT) >>
		dssu_pkg::LIM_SHIFT;

	logic [dssu_pkg::THR_W-1:0]    threshold_q;
	logic [dssu_pkg::FW_CFG_W-1:0] width_q;
	logic [dssu_pkg::FH_CFG_W-1:0] height_q;
	logic [dssu_pkg::LIM_W-1:0]    limit_q;
	logic [WEXT_W-1:0]             w_ext;
	logic [HEXT_W-1:0]             h_ext;
	logic [dssu_pkg::WID_W-1:0]    w_eff;
	logic [dssu_pkg::HGT_W-1:0]    h_eff;
	logic [dssu_pkg::LIM_W-1:0]    area;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= dssu_pkg::THR_W'(dssu_pkg::RST_THRESHOLD);
			width_q     <= dssu_pkg::FW_CFG_W'(dssu_pkg::RST_WIDTH);
			height_q    <= dssu_pkg::FH_CFG_W'(dssu_pkg::RST_HEIGHT);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dssu_pkg::REG_THRESHOLD: threshold_q <= cfg_wdata[dssu_pkg::THR_W-1:0];
				dssu_pkg::REG_WIDTH:     width_q <= cfg_wdata[dssu_pkg::FW_CFG_W-1:0];
				dssu_pkg::REG_HEIGHT:    height_q <= cfg_wdata[dssu_pkg::FH_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp width to 2..MAX_WIDTH and height to 1..MAX_HEIGHT
	always_comb begin
		w_ext = WEXT_W'(width_q);
		h_ext = HEXT_W'(height_q);
		if (w_ext < WEXT_W'(2))
			w_eff = dssu_pkg::WID_W'(2);
		else if (w_ext > WEXT_W'(dssu_pkg::MAX_WIDTH))
			w_eff = dssu_pkg::WID_W'(dssu_pkg::MAX_WIDTH);
		else
			w_eff = dssu_pkg::WID_W'(w_ext);
		if (h_ext < HEXT_W'(1))
			h_eff = dssu_pkg::HGT_W'(1);
		else if (h_ext > HEXT_W'(dssu_pkg::MAX_HEIGHT))
			h_eff = dssu_pkg::HGT_W'(dssu_pkg::MAX_HEIGHT);
		else
			h_eff = dssu_pkg::HGT_W'(h_ext);
		area = dssu_pkg::LIM_W'(w_eff) * dssu_pkg::LIM_W'(h_eff);
	end

	// frame size over eight, registered off the multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= dssu_pkg::LIM_W'(RST_LIMIT);
		else
			limit_q <= area >> dssu_pkg::LIM_SHIFT;
	end

	assign geom.threshold = threshold_q;
	assign geom.width     = w_eff;
	assign geom.half      = w_eff >> 1;
	assign geom.height    = h_eff;
	assign geom.limit     = limit_q;

endmodule
`default_nettype wire

FILE: hw/rtl/dssu_in_stage.sv
// input register: takes a pixel and registers its dark flag
`default_nettype none
module dssu_in_stage (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [dssu_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire logic [dssu_pkg::THR_W-1:0]        threshold,
	input  wire logic                              s1_done,
	output dssu_pkg::pix_t                         pix_s1
);

	logic                       valid_s1;
	logic                       dark_s1;
	logic [dssu_pkg::THR_W-1:0] rgb_sum;

	// r + g + b in ten bits
	always_comb begin
		rgb_sum = dssu_pkg::THR_W'(s_tdata[7:0]) + dssu_pkg::THR_W'(s_tdata[15:8]) +
			dssu_pkg::THR_W'(s_tdata[23:16]);
	end

	// register is free when empty or its pixel completes this cycle
	assign s_tready = !valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			dark_s1  <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			dark_s1  <= rgb_sum < threshold;
		end
	end

	assign pix_s1.valid = valid_s1;
	assign pix_s1.dark  = dark_s1;

endmodule
`default_nettype wire

FILE: hw/rtl/dssu_accum.sv
// position counters, half accumulators, found decision and result register
`default_nettype none
module dssu_accum (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dssu_pkg::geom_t                    geom,
	input  wire dssu_pkg::pix_t                     pix_s1,
	output logic                                    s1_done,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [dssu_pkg::OUT_TDATA_W-1:0]        m_tdata,
	output dssu_pkg::acc_stat_t                     stat
);

	localparam int TOT_W = dssu_pkg::COUNT_W + 1;

	logic [dssu_pkg::COL_W-1:0]   col_q;
	logic [dssu_pkg::ROW_W-1:0]   row_q;
	logic [dssu_pkg::COUNT_W-1:0] lcnt_q, rcnt_q, lcnt_n, rcnt_n;
	logic [dssu_pkg::SUM_W-1:0]   lrow_q, lcol_q, rrow_q, rcol_q;
	logic [dssu_pkg::SUM_W-1:0]   lrow_n, lcol_n, rrow_n, rcol_n;
	logic [dssu_pkg::WID_W-1:0]   col_inc;
	logic [dssu_pkg::HGT_W-1:0]   row_inc;
	logic                         col_wrap, row_wrap, last_pix;
	logic                         hit_l, hit_r;
	logic [TOT_W-1:0]             total;
	logic                         found;
	logic                         out_free;
	logic                         out_valid_q;
	logic [dssu_pkg::OUT_BITS-1:0] out_data_q;

	// position and next accumulator values
	always_comb begin
		col_inc  = dssu_pkg::WID_W'(col_q) + dssu_pkg::WID_W'(1);
		row_inc  = dssu_pkg::HGT_W'(row_q) + dssu_pkg::HGT_W'(1);
		col_wrap = !(col_inc < geom.width);
		row_wrap = !(row_inc < geom.height);
		last_pix = col_wrap && row_wrap;
		hit_l    = pix_s1.dark && (dssu_pkg::WID_W'(col_q) < geom.half);
		hit_r    = pix_s1.dark && !(dssu_pkg::WID_W'(col_q) < geom.half);
		lcnt_n   = hit_l ? dssu_pkg::sat_count(lcnt_q) : lcnt_q;
		lrow_n   = hit_l ? dssu_pkg::sat_sum(lrow_q, dssu_pkg::SUM_W'(row_q)) : lrow_q;
		lcol_n   = hit_l ? dssu_pkg::sat_sum(lcol_q, dssu_pkg::SUM_W'(col_q)) : lcol_q;
		rcnt_n   = hit_r ? dssu_pkg::sat_count(rcnt_q) : rcnt_q;
		rrow_n   = hit_r ? dssu_pkg::sat_sum(rrow_q, dssu_pkg::SUM_W'(row_q)) : rrow_q;
		rcol_n   = hit_r ? dssu_pkg::sat_sum(rcol_q, dssu_pkg::SUM_W'(col_q)) : rcol_q;
	end

	// seam decision on the frame totals
	always_comb begin
		total = TOT_W'(lcnt_n) + TOT_W'(rcnt_n);
		found = (lcnt_n != '0) && (rcnt_n != '0) &&
			(32'(total) > 32'(geom.width)) && (32'(total) <= 32'(geom.limit));
	end

	// pixel completes unless it closes a frame while the result is still held
	assign out_free = !out_valid_q || m_tready;
	assign s1_done  = pix_s1.valid && (!last_pix || out_free);

	// counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			lcnt_q <= '0;
			rcnt_q <= '0;
			lrow_q <= '0;
			lcol_q <= '0;
			rrow_q <= '0;
			rcol_q <= '0;
		end else if (s1_done) begin
			col_q <= col_wrap ? '0 : dssu_pkg::COL_W'(col_inc);
			if (col_wrap)
				row_q <= row_wrap ? '0 : dssu_pkg::ROW_W'(row_inc);
			if (last_pix) begin
				lcnt_q <= '0;
				rcnt_q <= '0;
				lrow_q <= '0;
				lcol_q <= '0;
				rrow_q <= '0;
				rcol_q <= '0;
			end else begin
				lcnt_q <= lcnt_n;
				rcnt_q <= rcnt_n;
				lrow_q <= lrow_n;
				lcol_q <= lcol_n;
				rrow_q <= rrow_n;
				rcol_q <= rcol_n;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_done && last_pix)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s1_done && last_pix)
			out_data_q <= {rcol_n, rrow_n, lcol_n, lrow_n, rcnt_n, lcnt_n, found};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = dssu_pkg::OUT_TDATA_W'(out_data_q);

	assign stat.frame_end = s1_done && last_pix;
	assign stat.col_zero  = (col_q == '0);
	assign stat.row_zero  = (row_q == '0);

endmodule
`default_nettype wire

FILE: hw/rtl/dark_seam_pixel_statistics_unit.sv
// Top level: dark pixel seam statistics over a raster-order RGB frame.
// Throughput: one pixel per clock; input register, then one accumulate stage into the
// result register. The only stall is a frame end while the previous result is still held.
// Result: the last pixel of a frame goes from the input register through the accumulate
// stage into the result register, where the frame result is then presented as valid.
// Reset (arst_n low): counters, accumulators and handshake flags clear at once and the
// configuration returns to threshold 80, width 128, height 128.
`default_nettype none
module dark_seam_pixel_statistics_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_wr_en,
	input  wire logic [dssu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dssu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// pixel stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16]
	input  wire logic [dssu_pkg::IN_TDATA_W-1:0]   s_tdata,
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// line_found [0], left_dark_count [14:1], right_dark_count [28:15],
	// left_row_sum [48:29], left_col_sum [68:49], right_row_sum [88:69],
	// right_col_sum [108:89], zero [111:109]
	output logic [dssu_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	dssu_pkg::geom_t     geom;
	dssu_pkg::pix_t      pix_s1;
	dssu_pkg::acc_stat_t stat;
	logic                s1_done;

	// configuration
	dssu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.geom      (geom)
	);

	// input register
	dssu_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.threshold (geom.threshold),
		.s1_done   (s1_done),
		.pix_s1    (pix_s1)
	);

	// accumulation and result register
	dssu_accum u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.pix_s1   (pix_s1),
		.s1_done  (s1_done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.stat     (stat)
	);

	// input only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back pressure");

	// frame end restarts the raster position and presents a result
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		stat.frame_end |=> (stat.col_zero && stat.row_zero && m_tvalid))
		else $error("frame end did not restart position or load result");

	// a found seam has dark pixels in both halves
	a_found_halves: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> ((m_tdata[14:1] != '0) && (m_tdata[28:15] != '0)))
		else $error("seam flagged with an empty half");

endmodule
`default_nettype wire
